// ===== hdl/qau_pkg.sv =====
// Shared types, opcodes and constants of the quaternion arithmetic unit.
`timescale 1ns / 1ps
package qau_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FracBitsDef = 27;

  // Width and reset value of the normalize tolerance register.
  localparam int TolW = 28;
  localparam logic [TolW-1:0] TolReset = TolW'(134);

  // Register index of the tolerance register on the configuration port.
  localparam logic RegTolerance = 1'b0;

  // Exact sum of four squares of 32-bit values, padded to an even width.
  localparam int SqW = 66;
  // Width of a rounded modulus and of a division quotient.
  localparam int ModW = 33;
  localparam int QuotW = 33;

  localparam logic [31:0] Max32 = 32'h7FFF_FFFF;
  localparam logic [31:0] Min32 = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_MUL   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_CONJ  = 4'd3,
    OP_SCALE = 4'd4,
    OP_LERP  = 4'd5,
    OP_DOT   = 4'd6,
    OP_SQMOD = 4'd7,
    OP_MOD   = 4'd8,
    OP_NORM  = 4'd9,
    OP_INV   = 4'd10,
    OP_ABS   = 4'd11
  } op_e;

  // Per-item data that travels beside the modulus and divider pipelines.
  typedef struct packed {
    op_e              op;
    logic [3:0][31:0] a;
    logic [3:0][31:0] r;
    logic [31:0]      scal;
    logic             sat;
    logic             zl;
    logic             pass;
  } side_t;

  // One finished result item.
  typedef struct packed {
    logic [3:0][31:0] r;
    logic [31:0]      scal;
    logic             zl;
    logic             sat;
  } res_t;

endpackage

// ===== hdl/qau_front.sv =====
// Front pipeline: products, rounding, sums and clipping of the direct operations.
`timescale 1ns / 1ps
module qau_front
  import qau_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  op_e                            operation_i,
  input  logic signed [31:0]             a_i [4],
  input  logic signed [31:0]             b_i [4],
  input  logic signed [31:0]             scalar_i,
  input  logic [TolW-1:0]                tol_i,
  output logic                           valid_o,
  output side_t                          side_o,
  output logic [67-FracBits:0]           l2_o,
  output logic [SqW-1:0]                 s_o
);

  localparam int ProdW = 66;
  localparam int RndW = ProdW - FracBits;
  localparam int SumW = RndW + 2;
  localparam logic signed [ProdW-1:0] Half = ProdW'(1) << (FracBits - 1);
  localparam logic [64:0] HalfSq = 65'(1) << (FracBits - 1);
  localparam logic signed [32:0] One33 = 33'(1) << FracBits;
  localparam logic [SumW-1:0] OneL = SumW'(1) << FracBits;
  localparam logic signed [SumW-1:0] MaxV = SumW'(32'sh7FFF_FFFF);
  localparam logic signed [SumW-1:0] MinV = ~MaxV;

  // Clip a wide value to 32 bits; the top bit flags clipping.
  function automatic logic [32:0] clip32(input logic signed [SumW-1:0] v);
    logic [32:0] res;
    if (v > MaxV) begin
      res = {1'b1, Max32};
    end else if (v < MinV) begin
      res = {1'b1, Min32};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  // Stage 1: operand selection and products.
  logic signed [32:0]       opa [4][4];
  logic signed [32:0]       opb [4][4];
  logic signed [ProdW-1:0]  p1_d [4][4];
  logic signed [63:0]       sq1_d [4];
  logic                     vld1_q;
  op_e                      op1_q;
  logic signed [ProdW-1:0]  p1_q [4][4];
  logic signed [63:0]       sq1_q [4];
  logic signed [31:0]       a1_q [4];
  logic signed [31:0]       b1_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        opa[i][j] = 33'(a_i[i]);
        opb[i][j] = 33'(b_i[j]);
      end
    end
    unique case (operation_i)
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          opa[i][0] = 33'(scalar_i);
          opb[i][0] = 33'(a_i[i]);
        end
      end
      OP_LERP: begin
        for (int i = 0; i < 4; i++) begin
          opa[i][0] = One33 - 33'(scalar_i);
          opb[i][0] = 33'(a_i[i]);
          opa[i][1] = 33'(scalar_i);
          opb[i][1] = 33'(b_i[i]);
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_d[i][j] = opa[i][j] * opb[i][j];
      end
      sq1_d[i] = a_i[i] * a_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q <= operation_i;
      p1_q  <= p1_d;
      sq1_q <= sq1_d;
      a1_q  <= a_i;
      b1_q  <= b_i;
    end
  end

  // Stage 2: round products to nearest, ties upward; exact sum of squares.
  logic signed [ProdW-1:0] pr_sum [4][4];
  logic [64:0]             sq_sum [4];
  logic signed [RndW-1:0]  rp2_d [4][4];
  logic [RndW-1:0]         rq2_d [4];
  logic [SqW-1:0]          s2_d;
  logic                    vld2_q;
  op_e                     op2_q;
  logic signed [RndW-1:0]  rp2_q [4][4];
  logic [RndW-1:0]         rq2_q [4];
  logic [SqW-1:0]          s2_q;
  logic signed [31:0]      a2_q [4];
  logic signed [31:0]      b2_q [4];

  always_comb begin
    s2_d = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pr_sum[i][j] = p1_q[i][j] + Half;
        rp2_d[i][j]  = pr_sum[i][j][ProdW-1:FracBits];
      end
      sq_sum[i] = {1'b0, $unsigned(sq1_q[i])} + HalfSq;
      rq2_d[i]  = RndW'(sq_sum[i][64:FracBits]);
      s2_d      = s2_d + SqW'($unsigned(sq1_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op2_q <= op1_q;
      rp2_q <= rp2_d;
      rq2_q <= rq2_d;
      s2_q  <= s2_d;
      a2_q  <= a1_q;
      b2_q  <= b1_q;
    end
  end

  // Stage 3: combine rounded products per operation.
  logic signed [SumW-1:0] x3 [4][4];
  logic signed [SumW-1:0] ae [4];
  logic signed [SumW-1:0] be [4];
  logic signed [SumW-1:0] v3_d [4];
  logic signed [SumW-1:0] vs3_d;
  logic [SumW-1:0]        l2_3_d;
  logic                   quat3_d;
  logic                   scal3_d;
  logic                   vld3_q;
  op_e                    op3_q;
  logic signed [SumW-1:0] v3_q [4];
  logic signed [SumW-1:0] vs3_q;
  logic [SumW-1:0]        l2_3_q;
  logic [SqW-1:0]         s3_q;
  logic                   quat3_q;
  logic                   scal3_q;
  logic signed [31:0]     a3_q [4];

  always_comb begin
    l2_3_d = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        x3[i][j] = SumW'(rp2_q[i][j]);
      end
      ae[i]   = SumW'(a2_q[i]);
      be[i]   = SumW'(b2_q[i]);
      v3_d[i] = '0;
      l2_3_d  = l2_3_d + SumW'(rq2_q[i]);
    end
    vs3_d   = '0;
    quat3_d = 1'b1;
    scal3_d = 1'b0;
    unique case (op2_q)
      OP_MUL: begin
        v3_d[0] = x3[3][0] + x3[0][3] + x3[1][2] - x3[2][1];
        v3_d[1] = x3[3][1] - x3[0][2] + x3[1][3] + x3[2][0];
        v3_d[2] = x3[3][2] + x3[0][1] - x3[1][0] + x3[2][3];
        v3_d[3] = x3[3][3] - x3[0][0] - x3[1][1] - x3[2][2];
      end
      OP_ADD: begin
        for (int i = 0; i < 4; i++) v3_d[i] = ae[i] + be[i];
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) v3_d[i] = ae[i] - be[i];
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) v3_d[i] = -ae[i];
        v3_d[3] = ae[3];
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) v3_d[i] = x3[i][0];
      end
      OP_LERP: begin
        for (int i = 0; i < 4; i++) v3_d[i] = x3[i][0] + x3[i][1];
      end
      OP_DOT: begin
        vs3_d   = x3[0][0] + x3[1][1] + x3[2][2] + x3[3][3];
        quat3_d = 1'b0;
        scal3_d = 1'b1;
      end
      OP_SQMOD: begin
        vs3_d   = $signed(l2_3_d);
        quat3_d = 1'b0;
        scal3_d = 1'b1;
      end
      OP_MOD: begin
        quat3_d = 1'b0;
        scal3_d = 1'b1;
      end
      OP_NORM: begin
        for (int i = 0; i < 4; i++) v3_d[i] = ae[i];
      end
      OP_INV: begin
      end
      OP_ABS: begin
        for (int i = 0; i < 4; i++) v3_d[i] = a2_q[i][31] ? -ae[i] : ae[i];
      end
      default: begin
        quat3_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op3_q   <= op2_q;
      v3_q    <= v3_d;
      vs3_q   <= vs3_d;
      l2_3_q  <= l2_3_d;
      s3_q    <= s2_q;
      quat3_q <= quat3_d;
      scal3_q <= scal3_d;
      a3_q    <= a2_q;
    end
  end

  // Stage 4: clipping, flags and the normalize pass-through test.
  logic [32:0]     cl [4];
  logic [32:0]     cls;
  logic [SumW-1:0] l2_gap;
  side_t           side_d;
  logic            vld4_q;
  side_t           side_q;
  logic [SumW-1:0] l2_4_q;
  logic [SqW-1:0]  s4_q;

  always_comb begin
    side_d.op  = op3_q;
    side_d.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      cl[i]         = clip32(v3_q[i]);
      side_d.a[i]   = a3_q[i];
      side_d.r[i]   = quat3_q ? cl[i][31:0] : '0;
      side_d.sat    = side_d.sat | (quat3_q & cl[i][32]);
    end
    cls         = clip32(vs3_q);
    side_d.scal = scal3_q ? cls[31:0] : '0;
    side_d.sat  = side_d.sat | (scal3_q & cls[32]);
    l2_gap      = (l2_3_q >= OneL) ? l2_3_q - OneL : OneL - l2_3_q;
    side_d.pass = (l2_3_q <= SumW'(tol_i)) || (l2_gap <= SumW'(tol_i)) || (s3_q == '0);
    side_d.zl   = (op3_q == OP_INV) && (l2_3_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      l2_4_q <= l2_3_q;
      s4_q   <= s3_q;
    end
  end

  assign valid_o = vld4_q;
  assign side_o  = side_q;
  assign l2_o    = l2_4_q;
  assign s_o     = s4_q;

endmodule

// ===== hdl/qau_sqrt.sv =====
// Pipelined rounded square root, one result bit per stage.
`timescale 1ns / 1ps
module qau_sqrt
  import qau_pkg::*;
#(
  parameter int CarryW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SqW-1:0]    s_i,
  input  logic [CarryW-1:0] carry_i,
  output logic              valid_o,
  output logic [ModW-1:0]   m_o,
  output logic [CarryW-1:0] carry_o
);

  localparam int Steps = ModW;
  localparam int RemW = ModW + 4;
  localparam int TrW = RemW - 2;

  logic              vld_q  [Steps];
  logic [SqW-1:0]    sh_q   [Steps];
  logic [RemW-1:0]   rem_q  [Steps];
  logic [ModW-1:0]   root_q [Steps];
  logic [CarryW-1:0] car_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic              vld_in;
    logic [SqW-1:0]    sh_in;
    logic [RemW-1:0]   rem_in;
    logic [ModW-1:0]   root_in;
    logic [CarryW-1:0] car_in;
    logic [RemW-1:0]   rem_sh;
    logic [RemW-1:0]   trial;
    logic [RemW-1:0]   rem_d;
    logic [ModW-1:0]   root_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign sh_in   = s_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign car_in  = carry_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign sh_in   = sh_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign car_in  = car_q[k-1];
    end

    // Bring down the next pair of bits and try the root bit.
    always_comb begin
      rem_sh = {rem_in[RemW-3:0], sh_in[SqW-1 -: 2]};
      trial  = {TrW'(root_in), 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[ModW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[ModW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sh_q[k]   <= sh_in << 2;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        car_q[k]  <= car_in;
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  logic              vld_r_q;
  logic [ModW-1:0]   m_r_q;
  logic [CarryW-1:0] car_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_r_q <= 1'b0;
    end else if (en_i) begin
      vld_r_q <= vld_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_r_q   <= root_q[Steps-1] +
                 ModW'(rem_q[Steps-1] > RemW'(root_q[Steps-1]));
      car_r_q <= car_q[Steps-1];
    end
  end

  assign valid_o = vld_r_q;
  assign m_o     = m_r_q;
  assign carry_o = car_r_q;

endmodule

// ===== hdl/qau_div.sv =====
// Pipelined rounding divider for normalize and inverse, and the result merge.
`timescale 1ns / 1ps
module qau_div
  import qau_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [ModW-1:0]           m_i,
  input  logic [67-FracBits:0]      l2_i,
  input  side_t                     side_i,
  output logic                      valid_o,
  output res_t                      res_o
);

  localparam int DivW = 68 - FracBits;
  localparam int NumW = ((32 + FracBits > DivW) ? 32 + FracBits : DivW) + 1;
  localparam int Steps = QuotW;

  // Prep stage: divisor, signs and numerators with the rounding half added.
  logic [DivW-1:0]  d_p;
  logic             neg_p [4];
  logic [31:0]      mag_p [4];
  logic [NumW-1:0]  num_p [4];
  logic             ovf_p [4];
  logic             p_vld_q;
  logic [DivW-1:0]  p_d_q;
  logic [DivW-1:0]  p_hi_q [4];
  logic [QuotW-1:0] p_lo_q [4];
  logic             p_ovf_q [4];
  logic             p_neg_q [4];
  side_t            p_side_q;
  logic [ModW-1:0]  p_m_q;

  always_comb begin
    d_p = (side_i.op == OP_INV) ? l2_i : DivW'(m_i);
    for (int i = 0; i < 4; i++) begin
      mag_p[i] = side_i.a[i][31] ? 32'd0 - side_i.a[i] : side_i.a[i];
      if ((side_i.op == OP_INV) && (i < 3)) begin
        neg_p[i] = ~side_i.a[i][31];
      end else begin
        neg_p[i] = side_i.a[i][31];
      end
      num_p[i] = (NumW'(mag_p[i]) << FracBits) + NumW'(d_p >> 1);
      ovf_p[i] = (num_p[i] >> QuotW) >= NumW'(d_p);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_d_q    <= d_p;
      p_side_q <= side_i;
      p_m_q    <= m_i;
      for (int i = 0; i < 4; i++) begin
        p_hi_q[i]  <= DivW'(num_p[i] >> QuotW);
        p_lo_q[i]  <= num_p[i][QuotW-1:0];
        p_ovf_q[i] <= ovf_p[i];
        p_neg_q[i] <= neg_p[i];
      end
    end
  end

  // Restoring division, one quotient bit per stage for all four lanes.
  logic             vld_q  [Steps];
  logic [DivW-1:0]  d_q    [Steps];
  logic [DivW-1:0]  hi_q   [Steps][4];
  logic [QuotW-1:0] lo_q   [Steps][4];
  logic             ovf_q  [Steps][4];
  logic             neg_q  [Steps][4];
  side_t            side_q [Steps];
  logic [ModW-1:0]  m_q    [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic             vld_in;
    logic [DivW-1:0]  d_in;
    logic [DivW-1:0]  hi_in [4];
    logic [QuotW-1:0] lo_in [4];
    logic             ovf_in [4];
    logic             neg_in [4];
    side_t            side_in;
    logic [ModW-1:0]  m_in;
    logic [DivW:0]    r2 [4];
    logic             ge [4];
    logic [DivW-1:0]  hi_d [4];

    if (k == 0) begin : g_first
      assign vld_in  = p_vld_q;
      assign d_in    = p_d_q;
      assign hi_in   = p_hi_q;
      assign lo_in   = p_lo_q;
      assign ovf_in  = p_ovf_q;
      assign neg_in  = p_neg_q;
      assign side_in = p_side_q;
      assign m_in    = p_m_q;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign d_in    = d_q[k-1];
      assign hi_in   = hi_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign ovf_in  = ovf_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign side_in = side_q[k-1];
      assign m_in    = m_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        r2[i]   = {hi_in[i], lo_in[i][QuotW-1]};
        ge[i]   = r2[i] >= {1'b0, d_in};
        hi_d[i] = ge[i] ? DivW'(r2[i] - {1'b0, d_in}) : DivW'(r2[i]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k]    <= d_in;
        side_q[k] <= side_in;
        m_q[k]    <= m_in;
        for (int i = 0; i < 4; i++) begin
          hi_q[k][i]  <= hi_d[i];
          lo_q[k][i]  <= {lo_in[i][QuotW-2:0], ge[i]};
          ovf_q[k][i] <= ovf_in[i];
          neg_q[k][i] <= neg_in[i];
        end
      end
    end
  end

  // Apply signs, clip, and merge with the directly computed results.
  logic [QuotW-1:0] q [4];
  logic [31:0]      qv [4];
  logic             qsat [4];
  logic             use_div;
  logic             any_qsat;
  side_t            sd;

  always_comb begin
    sd       = side_q[Steps-1];
    any_qsat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      q[i] = lo_q[Steps-1][i];
      if (neg_q[Steps-1][i]) begin
        qsat[i] = ovf_q[Steps-1][i] || (q[i] > {1'b0, Min32});
        qv[i]   = qsat[i] ? Min32 : 32'd0 - q[i][31:0];
      end else begin
        qsat[i] = ovf_q[Steps-1][i] || (q[i] > {1'b0, Max32});
        qv[i]   = qsat[i] ? Max32 : q[i][31:0];
      end
      any_qsat = any_qsat | qsat[i];
    end
    use_div = ((sd.op == OP_NORM) && !sd.pass) || ((sd.op == OP_INV) && !sd.zl);
    res_o.r    = sd.r;
    res_o.scal = sd.scal;
    res_o.zl   = sd.zl;
    res_o.sat  = sd.sat;
    if (use_div) begin
      for (int i = 0; i < 4; i++) res_o.r[i] = qv[i];
      res_o.sat = sd.sat | any_qsat;
    end
    if (sd.op == OP_MOD) begin
      if (m_q[Steps-1] > {1'b0, Max32}) begin
        res_o.scal = Max32;
        res_o.sat  = 1'b1;
      end else begin
        res_o.scal = m_q[Steps-1][31:0];
      end
    end
  end

  assign valid_o = vld_q[Steps-1];

endmodule

// ===== hdl/quaternion_arithmetic_unit.sv =====
// Top level of the quaternion arithmetic unit: channels, configuration and output register.
//
// Usage:
// - Input channel: a request (operation, a, b, scalar_in) is taken at a rising
//   edge with valid_i high and stall_o low. Output channel: a result is taken
//   at a rising edge with valid_o high and stall_i low.
// - Every request gives exactly one result, in request order.
// - Path from request to result: 4 front stages (products, rounding, sums,
//   clipping), 33 square-root stages plus a rounding stage, a divider prep
//   stage and 33 divider stages, and the output register. All operations
//   take the same path.
// - Throughput is one request per cycle; the whole pipeline advances whenever
//   the output register is empty or being taken.
// - When the receiver stalls with a result waiting, the pipeline holds every
//   stage and stall_o rises; nothing is lost or repeated.
// - The APB port holds the normalize tolerance at byte address 0; it resets to 134.
//   The user must write it only while no request is in flight; the block does not check.
// - Reset empties the pipeline at once; no clearing pass is needed.
`timescale 1ns / 1ps
module quaternion_arithmetic_unit
  import qau_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [3:0]  operation_i,
  input  logic [31:0] a_x_i,
  input  logic [31:0] a_y_i,
  input  logic [31:0] a_z_i,
  input  logic [31:0] a_w_i,
  input  logic [31:0] b_x_i,
  input  logic [31:0] b_y_i,
  input  logic [31:0] b_z_i,
  input  logic [31:0] b_w_i,
  input  logic [31:0] scalar_in_i,
  // Result channel
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] r_x_o,
  output logic [31:0] r_y_o,
  output logic [31:0] r_z_o,
  output logic [31:0] r_w_o,
  output logic [31:0] scalar_out_o,
  output logic        zero_length_o,
  output logic        saturated_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SumW = 68 - FracBits;
  localparam int CarryW = $bits(side_t) + SumW;

  // Tolerance register.
  logic [TolW-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegTolerance)) begin
      tol_q <= pwdata[TolW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegTolerance) ? 32'(tol_q) : 32'd0;

  // Pipeline advance: hold everything while a finished result is stalled.
  logic en;
  logic out_vld_q;
  res_t res_q;

  assign en      = !out_vld_q || !stall_i;
  assign stall_o = !en;

  // Front stages.
  logic signed [31:0] a_vec [4];
  logic signed [31:0] b_vec [4];
  logic               f_vld;
  side_t              f_side;
  logic [SumW-1:0]    f_l2;
  logic [SqW-1:0]     f_s;

  assign a_vec = '{a_x_i, a_y_i, a_z_i, a_w_i};
  assign b_vec = '{b_x_i, b_y_i, b_z_i, b_w_i};

  qau_front #(
    .FracBits (FracBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (valid_i),
    .operation_i (op_e'(operation_i)),
    .a_i         (a_vec),
    .b_i         (b_vec),
    .scalar_i    (scalar_in_i),
    .tol_i       (tol_q),
    .valid_o     (f_vld),
    .side_o      (f_side),
    .l2_o        (f_l2),
    .s_o         (f_s)
  );

  // Modulus stages.
  logic              s_vld;
  logic [ModW-1:0]   s_m;
  logic [CarryW-1:0] s_carry;
  side_t             s_side;
  logic [SumW-1:0]   s_l2;

  qau_sqrt #(
    .CarryW (CarryW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .s_i     (f_s),
    .carry_i ({f_side, f_l2}),
    .valid_o (s_vld),
    .m_o     (s_m),
    .carry_o (s_carry)
  );

  assign {s_side, s_l2} = s_carry;

  // Divider stages and result merge.
  logic d_vld;
  res_t d_res;

  qau_div #(
    .FracBits (FracBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_vld),
    .m_i     (s_m),
    .l2_i    (s_l2),
    .side_i  (s_side),
    .valid_o (d_vld),
    .res_o   (d_res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && d_vld) begin
      res_q <= d_res;
    end
  end

  assign valid_o       = out_vld_q;
  assign r_x_o         = res_q.r[0];
  assign r_y_o         = res_q.r[1];
  assign r_z_o         = res_q.r[2];
  assign r_w_o         = res_q.r[3];
  assign scalar_out_o  = res_q.scal;
  assign zero_length_o = res_q.zl;
  assign saturated_o   = res_q.sat;

  // A zero-length inverse gives an all-zero quaternion and no clipping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_length_o |-> (r_x_o == 32'd0) && (r_y_o == 32'd0) &&
      (r_z_o == 32'd0) && (r_w_o == 32'd0) && !saturated_o && (scalar_out_o == 32'd0))
    else $error("zero-length result carries nonzero fields");

  // No operation fills both the scalar and the quaternion fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (scalar_out_o != 32'd0) |-> (r_x_o == 32'd0) && (r_y_o == 32'd0) &&
      (r_z_o == 32'd0) && (r_w_o == 32'd0) && !zero_length_o)
    else $error("scalar and quaternion results both present");

  // A tolerance write lands in the register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == RegTolerance) |=>
      tol_q == $past(pwdata[TolW-1:0]))
    else $error("tolerance write lost");

endmodule

// ===== bench/tb_quaternion_arithmetic_unit.sv =====
// Testbench of the quaternion arithmetic unit: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  localparam int Frac = FracBitsDef;
  localparam longint QOne = longint'(1) << Frac;
  localparam longint QHalf = longint'(1) << (Frac - 1);
  localparam longint MaxVal = 64'sd2147483647;
  localparam longint MinVal = -64'sd2147483648;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a[4];
    logic [31:0] b[4];
    logic [31:0] s;
  } quat_req_t;

  typedef struct {
    logic [31:0] r[4];
    logic [31:0] scal;
    logic        zl;
    logic        sat;
  } quat_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] r_x_o, r_y_o, r_z_o, r_w_o, scalar_out_o;
  logic        zero_length_o, saturated_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  quat_req_t   pending_reqs[$];
  quat_res_t   expected_res[$];
  quat_req_t   cur_req;
  quat_req_t   next_req;
  logic [27:0] tol_model = TolReset;
  int          n_sent = 0;
  int          n_recv = 0;
  int          n_errors = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  initial begin
    cur_req.op = '0;
    cur_req.s  = '0;
    for (int i = 0; i < 4; i++) begin
      cur_req.a[i] = '0;
      cur_req.b[i] = '0;
    end
  end

  always #5 clk_i = ~clk_i;

  quaternion_arithmetic_unit dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .operation_i(cur_req.op),
    .a_x_i(cur_req.a[0]), .a_y_i(cur_req.a[1]), .a_z_i(cur_req.a[2]), .a_w_i(cur_req.a[3]),
    .b_x_i(cur_req.b[0]), .b_y_i(cur_req.b[1]), .b_z_i(cur_req.b[2]), .b_w_i(cur_req.b[3]),
    .scalar_in_i(cur_req.s),
    .valid_o, .stall_i, .r_x_o, .r_y_o, .r_z_o, .r_w_o, .scalar_out_o,
    .zero_length_o, .saturated_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Fixed-point product rounded to nearest, ties toward plus infinity.
  function automatic longint fx_mul(longint x, longint y);
    return (x * y + QHalf) >>> Frac;
  endfunction

  // Division by a positive divisor, rounded to nearest, ties away from zero.
  function automatic longint div_nearest(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  // Square root rounded to the nearest integer.
  function automatic longint root_nearest(logic [65:0] n);
    logic [65:0] r;
    logic [65:0] bitv;
    r = '0;
    bitv = 66'b1 << 64;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (n > r) r = r + 1;
    return longint'(r);
  endfunction

  function automatic logic [31:0] clamp32(longint v, ref logic sat);
    if (v > MaxVal) begin
      sat = 1'b1;
      return MaxVal[31:0];
    end
    if (v < MinVal) begin
      sat = 1'b1;
      return MinVal[31:0];
    end
    return v[31:0];
  endfunction

  // Expected result of one request under the current tolerance.
  function automatic quat_res_t quat_predict(quat_req_t q);
    quat_res_t   res;
    longint      a[4], b[4], r[4];
    longint      s, scal, l2, m, d1;
    logic [65:0] sumsq;
    logic        sat, is_quat, is_scal;
    sat = 1'b0;
    is_quat = 1'b1;
    is_scal = 1'b0;
    scal = 0;
    res.zl = 1'b0;
    s = longint'(signed'(q.s));
    sumsq = '0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'(signed'(q.a[i]));
      b[i] = longint'(signed'(q.b[i]));
      r[i] = 0;
      sumsq = sumsq + 66'(a[i] * a[i]);
    end
    l2 = fx_mul(a[0], a[0]) + fx_mul(a[1], a[1]) + fx_mul(a[2], a[2]) + fx_mul(a[3], a[3]);
    m = root_nearest(sumsq);
    case (q.op)
      OP_MUL: begin
        r[0] = fx_mul(a[3], b[0]) + fx_mul(a[0], b[3]) + fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]);
        r[1] = fx_mul(a[3], b[1]) - fx_mul(a[0], b[2]) + fx_mul(a[1], b[3]) + fx_mul(a[2], b[0]);
        r[2] = fx_mul(a[3], b[2]) + fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]) + fx_mul(a[2], b[3]);
        r[3] = fx_mul(a[3], b[3]) - fx_mul(a[0], b[0]) - fx_mul(a[1], b[1]) - fx_mul(a[2], b[2]);
      end
      OP_ADD:   for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
      OP_SUB:   for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) r[i] = -a[i];
        r[3] = a[3];
      end
      OP_SCALE: for (int i = 0; i < 4; i++) r[i] = fx_mul(s, a[i]);
      OP_LERP:
        for (int i = 0; i < 4; i++) r[i] = fx_mul(QOne - s, a[i]) + fx_mul(s, b[i]);
      OP_DOT: begin
        scal = fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2])
             + fx_mul(a[3], b[3]);
        is_quat = 1'b0;
        is_scal = 1'b1;
      end
      OP_SQMOD: begin
        scal = l2;
        is_quat = 1'b0;
        is_scal = 1'b1;
      end
      OP_MOD: begin
        scal = m;
        is_quat = 1'b0;
        is_scal = 1'b1;
      end
      OP_NORM: begin
        d1 = l2 - QOne;
        if (d1 < 0) d1 = -d1;
        // Near-zero or near-unit length, or zero modulus: a passes through.
        if (l2 <= longint'(tol_model) || d1 <= longint'(tol_model) || m == 0) begin
          for (int i = 0; i < 4; i++) r[i] = a[i];
        end else begin
          for (int i = 0; i < 4; i++) r[i] = div_nearest(a[i] * QOne, m);
        end
      end
      OP_INV: begin
        if (l2 == 0) begin
          res.zl = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) r[i] = div_nearest(-a[i] * QOne, l2);
          r[3] = div_nearest(a[3] * QOne, l2);
        end
      end
      OP_ABS:   for (int i = 0; i < 4; i++) r[i] = (a[i] < 0) ? -a[i] : a[i];
      default:  is_quat = 1'b0;
    endcase
    for (int i = 0; i < 4; i++) res.r[i] = is_quat ? clamp32(r[i], sat) : '0;
    res.scal = is_scal ? clamp32(scal, sat) : '0;
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", n_recv, field, got, want);
    n_errors++;
  endtask

  // Sender: offers queued requests, idling at random outside a quiet window.
  always @(posedge clk_i) begin
    if (rst_ni && !(valid_i && stall_o)) begin
      if (valid_i) begin
        expected_res.push_back(quat_predict(cur_req));
        n_sent++;
      end
      if (pending_reqs.size() > 0 &&
          ((n_sent >= 300 && n_sent < 450) || $urandom_range(99) >= 13)) begin
        next_req = pending_reqs.pop_front();
        cur_req <= next_req;
        valid_i <= 1'b1;
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each result, stalls at random and once for a long stretch.
  always @(posedge clk_i) begin
    quat_res_t want;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (expected_res.size() == 0) begin
          $display("unexpected result %0d", n_recv);
          n_errors++;
        end else begin
          want = expected_res.pop_front();
          if (r_x_o !== want.r[0]) report_mismatch("r_x", r_x_o, want.r[0]);
          if (r_y_o !== want.r[1]) report_mismatch("r_y", r_y_o, want.r[1]);
          if (r_z_o !== want.r[2]) report_mismatch("r_z", r_z_o, want.r[2]);
          if (r_w_o !== want.r[3]) report_mismatch("r_w", r_w_o, want.r[3]);
          if (scalar_out_o !== want.scal) report_mismatch("scalar_out", scalar_out_o, want.scal);
          if (zero_length_o !== want.zl)
            report_mismatch("zero_length", 32'(zero_length_o), 32'(want.zl));
          if (saturated_o !== want.sat)
            report_mismatch("saturated", 32'(saturated_o), 32'(want.sat));
        end
        n_recv++;
      end
      if (!hold_done && n_recv >= 150) begin
        hold_done <= 1'b1;
        hold_left <= 200;
        stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        stall_i <= 1'b1;
      end else begin
        stall_i <= (n_recv >= 300 && n_recv < 450) ? 1'b0 : ($urandom_range(99) < 13);
      end
    end
  end

  // Random component: half near unit scale, the rest full range, tiny and edge values.
  function automatic logic [31:0] rand_comp();
    int unsigned pick;
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0800_0000};
    pick = $urandom_range(99);
    if (pick < 25) return $urandom;
    if (pick < 75) return 32'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
    if (pick < 85) return edges[$urandom_range(5)];
    return 32'($signed($urandom_range(510)) - 255);
  endfunction

  task automatic add_req(logic [3:0] op, logic [31:0] a0, a1, a2, a3,
                         logic [31:0] b0, b1, b2, b3, logic [31:0] s);
    quat_req_t q;
    q.op = op;
    q.a = '{a0, a1, a2, a3};
    q.b = '{b0, b1, b2, b3};
    q.s = s;
    pending_reqs.push_back(q);
  endtask

  task automatic add_random(int n);
    quat_req_t q;
    for (int k = 0; k < n; k++) begin
      q.op = ($urandom_range(99) < 90) ? 4'($urandom_range(11)) : 4'($urandom_range(15, 12));
      for (int i = 0; i < 4; i++) begin
        q.a[i] = rand_comp();
        q.b[i] = rand_comp();
      end
      q.s = rand_comp();
      pending_reqs.push_back(q);
    end
  endtask

  // Waits until every request is sent and every result has come back.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || valid_i || expected_res.size() != 0);
  endtask

  task automatic write_tolerance(logic [27:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= 32'(v);
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tol_model = v;
  endtask

  initial begin
    localparam logic [31:0] Mx = 32'h7FFF_FFFF;
    localparam logic [31:0] Mn = 32'h8000_0000;
    localparam logic [31:0] One = 32'h0800_0000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset tolerance.
    add_req(OP_MUL, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, 0);
    add_req(OP_MUL, Mn, Mn, Mn, Mn, Mx, Mn, Mx, Mn, 0);
    add_req(OP_MUL, 0, 0, 0, One, 32'h1234_5678, 32'hF000_0001, 5, One, 0);
    add_req(OP_ADD, Mx, Mn, Mx, 1, 1, Mn, Mn, 2, 0);
    add_req(OP_SUB, Mn, Mx, 0, 1, 1, Mn, Mn, 2, 0);
    add_req(OP_CONJ, Mn, Mn, Mn, Mn, 0, 0, 0, 0, 0);
    add_req(OP_SCALE, Mx, Mn, One, 3, 0, 0, 0, 0, Mn);
    add_req(OP_SCALE, Mx, Mn, One, 3, 0, 0, 0, 0, Mx);
    add_req(OP_LERP, Mx, Mn, One, 7, Mn, Mx, 0, 9, 0);
    add_req(OP_LERP, Mx, Mn, One, 7, Mn, Mx, 0, 9, One);
    add_req(OP_LERP, Mx, Mn, One, 7, Mn, Mx, 0, 9, Mn);
    add_req(OP_DOT, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, 0);
    add_req(OP_SQMOD, Mn, Mn, Mn, Mn, 0, 0, 0, 0, 0);
    add_req(OP_MOD, Mn, Mn, Mn, Mn, 0, 0, 0, 0, 0);
    add_req(OP_MOD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_req(OP_NORM, 0, 0, 0, One, 0, 0, 0, 0, 0);
    add_req(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_req(OP_NORM, One, One, 0, One, 0, 0, 0, 0, 0);
    add_req(OP_NORM, Mx, Mn, 1, 0, 0, 0, 0, 0, 0);
    add_req(OP_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_req(OP_INV, 1, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0, 0);
    add_req(OP_INV, 0, 0, 32'h0000_4000, 0, 0, 0, 0, 0, 0);
    add_req(OP_INV, 1000, 2000, 3000, One, 0, 0, 0, 0, 0);
    add_req(OP_ABS, Mn, Mx, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    add_req(4'd12, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx);
    add_req(4'd15, Mn, Mn, Mn, Mn, Mn, Mn, Mn, Mn, Mn);
    drain();

    // Random phases over several tolerance settings.
    write_tolerance(28'd0);
    add_random(200);
    drain();
    write_tolerance(28'd134217728);
    add_random(150);
    drain();
    write_tolerance(28'($urandom_range(134217728)));
    add_random(200);
    drain();
    write_tolerance(28'd134);
    add_random(150);
    drain();

    repeat (80) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/qau_pkg.sv
hdl/qau_front.sv
hdl/qau_sqrt.sv
hdl/qau_div.sv
hdl/quaternion_arithmetic_unit.sv
bench/tb_quaternion_arithmetic_unit.sv
